FILE: rtl/core/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, widths and the sRGB threshold table for the linear to sRGB
// 8-bit encoder. The table is built at elaboration with exact integer math.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int CODE_W  = 8;
    localparam int KEY_W   = 31;
    localparam int VALUE_W = 32;
    localparam int NUM_THR = 1 << CODE_W;
    localparam int BIG_W   = 1024;

    // Bit pattern of 1.0 and the largest key, which lies above every threshold.
    localparam logic [KEY_W-1:0] ONE_BITS = 31'h3F80_0000;
    localparam logic [KEY_W-1:0] KEY_MAX  = '1;
    localparam logic [7:0]       EXP_MAX  = 8'hFF;

    typedef logic [NUM_THR-1:0][KEY_W-1:0] t_thr_tab;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] code;
    } t_srch;

    function automatic logic [BIG_W-1:0] big_pow(logic [BIG_W-1:0] base, int n);
        logic [BIG_W-1:0] acc;
        acc = BIG_W'(1);
        for (int i = 0; i < n; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // True when the encoded value of the positive float x is at least k.
    function automatic logic code_at_least(logic [KEY_W-1:0] x, int k,
                                           logic [BIG_W-1:0] c12,
                                           logic [BIG_W-1:0] p12);
        logic [BIG_W-1:0] m;
        logic [BIG_W-1:0] m5;
        logic             lin;
        int               s;
        if (x[30:23] == 8'd0) begin
            m = BIG_W'(x[22:0]);
            s = 149;
        end else begin
            m = BIG_W'({1'b1, x[22:0]});
            s = 150 - int'(x[30:23]);
        end
        lin = (s >= 49) || ((m * BIG_W'(10000000)) < (BIG_W'(31308) << s));
        if (lin) begin
            return (m * BIG_W'(32946)) >= ((BIG_W'(k) * BIG_W'(10)) << s);
        end
        m5 = m * m * m * m * m;
        return (m5 * c12) >= (p12 << (5 * s));
    endfunction

    // Entry k holds the smallest non-negative float pattern whose code is at
    // least k. Entry zero is never read.
    function automatic t_thr_tab build_thr_tab();
        t_thr_tab         tab;
        logic [BIG_W-1:0] c12;
        logic [BIG_W-1:0] p12;
        int               lo;
        int               hi;
        int               mid;
        int               prev;
        tab  = '0;
        c12  = big_pow(BIG_W'(269025), 12);
        prev = 1;
        for (int k = 1; k < NUM_THR; k++) begin
            p12 = big_pow(BIG_W'(1000 * k + 14025), 12);
            lo  = prev - 1;
            hi  = int'(ONE_BITS);
            while (hi - lo > 1) begin
                mid = (lo + hi) >> 1;
                if (code_at_least(KEY_W'(mid), k, c12, p12)) begin
                    hi = mid;
                end else begin
                    lo = mid;
                end
            end
            tab[k] = KEY_W'(hi);
            prev   = hi;
        end
        return tab;
    endfunction

    localparam t_thr_tab THR_TAB = build_thr_tab();

endpackage

FILE: rtl/core/lts_classify.sv
// ----------------------------------------------------------------------------
// lts_classify
// First pipeline stage: folds the special float classes into a search key.
// ----------------------------------------------------------------------------
module lts_classify (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [lts_pkg::VALUE_W-1:0] i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output lts_pkg::t_srch             o_data
);
    import lts_pkg::*;

    logic                r_valid;
    t_srch               r_data;
    logic [KEY_W-1:0]    n_key;
    logic                is_nan;

    assign o_ready = !r_valid || i_ready;
    assign is_nan  = (i_value[30:23] == EXP_MAX) && (i_value[22:0] != 23'd0);

    // Negatives and NaN go to key zero, which lies below every threshold.
    // One and above, infinity included, saturate above all thresholds.
    always_comb begin
        priority if (i_value[31] || is_nan) begin
            n_key = '0;
        end else if (i_value[30:0] >= ONE_BITS) begin
            n_key = KEY_MAX;
        end else begin
            n_key = i_value[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data.key  <= n_key;
            r_data.code <= '0;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/lts_search_stage.sv
// ----------------------------------------------------------------------------
// lts_search_stage
// One level of the pipelined binary search over the threshold table.
// ----------------------------------------------------------------------------
module lts_search_stage #(
    parameter int LEVEL = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lts_pkg::t_srch i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output lts_pkg::t_srch o_data
);
    import lts_pkg::*;

    localparam logic [CODE_W-1:0] TRY_BIT = CODE_W'(1) << (CODE_W - 1 - LEVEL);

    logic              r_valid;
    t_srch             r_data;
    logic [CODE_W-1:0] cand;
    t_srch             n_data;

    assign o_ready = !r_valid || i_ready;
    assign cand    = i_data.code | TRY_BIT;

    always_comb begin
        n_data.key  = i_data.key;
        n_data.code = (THR_TAB[cand] <= i_data.key) ? cand : i_data.code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/linear_to_srgb8_encoder_core.sv
// ----------------------------------------------------------------------------
// linear_to_srgb8_encoder_core
// Converts a linear intensity in single precision to the truncated 8-bit
// sRGB code by a pipelined binary search over 255 constant thresholds.
//
//   channel  | valid    | stall    | payload
//   ---------+----------+----------+------------------------------
//   request  | i_valid  | o_stall  | i_linear_value [31:0]
//   result   | o_valid  | i_stall  | o_srgb_code    [7:0]
//
// One request enters per clock while o_stall is low. Each request passes
// through a classification stage and one search stage per bit of the
// eight-level search. Every stage has its own valid bit, so empty stages
// keep taking requests while a result waits at the output. A stall holds
// only the stages that are full. Reset clears the valid bits.
// ----------------------------------------------------------------------------
module linear_to_srgb8_encoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lts_pkg::VALUE_W-1:0] i_linear_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lts_pkg::CODE_W-1:0]  o_srgb_code
);
    import lts_pkg::*;

    logic  stg_valid [CODE_W+1];
    logic  stg_ready [CODE_W+1];
    t_srch stg_data  [CODE_W+1];
    logic  cls_ready;

    lts_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (cls_ready),
        .i_value (i_linear_value),
        .o_valid (stg_valid[0]),
        .i_ready (stg_ready[0]),
        .o_data  (stg_data[0])
    );

    for (genvar g = 0; g < CODE_W; g++) begin : g_search
        lts_search_stage #(
            .LEVEL (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    assign stg_ready[CODE_W] = !i_stall;
    assign o_stall           = !cls_ready;
    assign o_valid           = stg_valid[CODE_W];
    assign o_srgb_code       = stg_data[CODE_W].code;

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear to sRGB 8-bit encoder core. A short
// table of fixed requests covers the sign, NaN, infinity, denormal, 1.0 and
// curve-break cases. Random requests follow under three idling patterns,
// including a long output hold-off that backs the pipeline up. Every result
// is compared with a fixed code or an exact big-integer transfer curve model.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 345;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 30;
    localparam int STALL_LIMIT     = 2000;

    localparam logic CODE_KNOWN   = 1'b1;
    localparam logic CODE_PREDICT = 1'b0;

    // Bit pattern just below the break between the linear segment
    // and the power curve.
    localparam logic [31:0] KNEE_BITS = 32'h3B4D_2E1B;
    localparam logic [31:0] ONE_F     = 32'h3F80_0000;

    typedef logic [511:0] t_wide;

    typedef struct packed {
        logic [31:0] value;
        logic        known;
        logic [7:0]  code;
    } t_row;

    typedef struct {
        logic [lts_pkg::VALUE_W-1:0] value;
        logic [lts_pkg::CODE_W-1:0]  code;
    } t_expect;

    localparam t_row DIRECTED_ROWS [0:21] = '{
        {32'h0000_0000, CODE_KNOWN,   8'd0},
        {32'h8000_0000, CODE_KNOWN,   8'd0},
        {32'hBF80_0000, CODE_KNOWN,   8'd0},
        {32'hFF80_0000, CODE_KNOWN,   8'd0},
        {32'hFFFF_FFFF, CODE_KNOWN,   8'd0},
        {32'h7FC0_0000, CODE_KNOWN,   8'd0},
        {32'h7F80_0001, CODE_KNOWN,   8'd0},
        {32'h7FFF_FFFF, CODE_KNOWN,   8'd0},
        {32'h7F80_0000, CODE_KNOWN,   8'd255},
        {32'h7F7F_FFFF, CODE_KNOWN,   8'd255},
        {32'h3F80_0000, CODE_KNOWN,   8'd255},
        {32'h4000_0000, CODE_KNOWN,   8'd255},
        {32'h3F7F_FFFF, CODE_PREDICT, 8'd0},
        {32'h0000_0001, CODE_KNOWN,   8'd0},
        {32'h007F_FFFF, CODE_KNOWN,   8'd0},
        {32'h0080_0000, CODE_KNOWN,   8'd0},
        {32'h3B4D_2E1B, CODE_PREDICT, 8'd0},
        {32'h3B4D_2E1C, CODE_PREDICT, 8'd0},
        {32'h3F00_0000, CODE_PREDICT, 8'd0},
        {32'h3E80_0000, CODE_PREDICT, 8'd0},
        {32'h3C23_D70A, CODE_PREDICT, 8'd0},
        {32'h3A80_0000, CODE_PREDICT, 8'd0}
    };

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_valid        = 1'b0;
    logic                        o_stall;
    logic [lts_pkg::VALUE_W-1:0] i_linear_value = '0;
    logic                        o_valid;
    logic                        i_stall        = 1'b0;
    logic [lts_pkg::CODE_W-1:0]  o_srgb_code;

    t_expect pending_codes[$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    int      hold_requests  = 0;
    int      quiet_cycles   = 0;

    linear_to_srgb8_encoder_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_linear_value (i_linear_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_srgb_code    (o_srgb_code)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_wide wide_pow(t_wide base, int n);
        t_wide acc;
        acc = t_wide'(1);
        for (int i = 0; i < n; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // Exact encoding of one float pattern. The input is m * 2^-s; the power
    // segment compares m^5 * 269025^12 with (1000k + 14025)^12 * 2^(5s).
    function automatic logic [7:0] encode_srgb(logic [31:0] x);
        logic [7:0]   ex;
        logic [22:0]  fr;
        logic [23:0]  m;
        logic [127:0] prod;
        t_wide        lhs;
        t_wide        rhs;
        int           s;
        int           lo;
        int           hi;
        int           mid;
        ex = x[30:23];
        fr = x[22:0];
        if (x[31]) begin
            return 8'd0;
        end
        if (ex == 8'hFF) begin
            return (fr != 23'd0) ? 8'd0 : 8'd255;
        end
        if (x >= ONE_F) begin
            return 8'd255;
        end
        if (x == 32'd0) begin
            return 8'd0;
        end
        m = (ex == 8'd0) ? {1'b0, fr} : {1'b1, fr};
        s = (ex == 8'd0) ? 149 : 150 - int'(ex);
        if (s >= 49 || (128'(m) * 128'd10000000) < (128'd31308 << s)) begin
            if (s >= 64) begin
                return 8'd0;
            end
            prod = 128'(m) * 128'd32946;
            return 8'((prod >> s) / 128'd10);
        end
        lhs = wide_pow(t_wide'(m), 5) * wide_pow(t_wide'(269025), 12);
        lo  = 0;
        hi  = 256;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            rhs = wide_pow(t_wide'(1000 * mid + 14025), 12) << (5 * s);
            if (lhs >= rhs) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return 8'(lo);
    endfunction

    // Smallest non-negative pattern whose code reaches k, for k in 1..255.
    function automatic logic [31:0] find_threshold(int k);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = ONE_F;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (int'(encode_srgb(mid)) >= k) begin
                hi = mid;
            end else begin
                lo = mid;
            end
        end
        return hi;
    endfunction

    function automatic logic [31:0] pick_linear_value();
        int          sel;
        logic [31:0] t;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            return $urandom_range(0, ONE_F - 1);
        end else if (sel < 55) begin
            return {1'b0, 8'($urandom_range(118, 126)), 23'($urandom)};
        end else if (sel < 65) begin
            return KNEE_BITS - 32'd64 + 32'($urandom_range(0, 128));
        end else if (sel < 80) begin
            t = find_threshold($urandom_range(1, 255));
            return t - 32'd2 + 32'($urandom_range(0, 3));
        end else if (sel < 90) begin
            return $urandom;
        end else if (sel < 95) begin
            case ($urandom_range(0, 3))
                0: return {1'b1, 31'($urandom)};
                1: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
                2: return {9'd0, 23'($urandom)};
                default: return $urandom_range(ONE_F, 32'h7F80_0000);
            endcase
        end
        return {1'b0, 8'($urandom_range(100, 117)), 23'($urandom)};
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [31:0] value, input logic known,
                                input logic [7:0] code);
        t_expect item;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_linear_value <= value;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        item.value = value;
        item.code  = (known == CODE_KNOWN) ? code : encode_srgb(value);
        pending_codes.push_back(item);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_expect head;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_codes.size() == 0) begin
                report_mismatch($sformatf("unexpected code %0d", o_srgb_code));
            end else begin
                head = pending_codes.pop_front();
                if (o_srgb_code !== head.code) begin
                    report_mismatch($sformatf("input %08h: code %0d, expected %0d",
                                              head.value, o_srgb_code, head.code));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The hold-off is counted here so that the sender keeps offering
    // requests while the output is blocked.
    initial begin : drive_result_stall
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    initial begin : run_stimulus
        t_row row;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            send_request(row.value, row.known, row.code);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_requests++;
                end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                send_request(pick_linear_value(), CODE_PREDICT, 8'd0);
            end
        end
        i_valid <= 1'b0;

        while (pending_codes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_codes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: linear_to_srgb8_encoder_core.f
rtl/core/lts_pkg.sv
rtl/core/lts_classify.sv
rtl/core/lts_search_stage.sv
rtl/core/linear_to_srgb8_encoder_core.sv
bench/tb.sv
